>>> design/assert_macros.svh
// Assertion macros used by the ring map datapath.
// Needs clk_i and rst_ni in the including module's scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define RSOM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define RSOM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RSOM_ASSERT(lbl, prop, msg)
`define RSOM_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> design/rsom_pkg.sv
// Shared constants, types and command/status structs of the ring map.
// No dependencies.
`default_nettype none
package rsom_pkg;
  localparam int NEURON_COUNT = 256;
  localparam int ADDR_W       = $clog2(NEURON_COUNT);
  localparam int VAL_W        = 17;
  localparam int GAIN_W       = 16;
  localparam int REACH_W      = 9;
  localparam int HITS_W       = 24;
  localparam int MOT_W        = 48;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 9;
  localparam int F_W          = 17;
  localparam int DIVD_W       = REACH_W + 16;
  localparam int GF_W         = GAIN_W + F_W;
  localparam int SQ_W         = 2 * VAL_W;
  localparam int DIST_W       = SQ_W + 1;
  localparam int CNT_W        = $clog2(DIVD_W);

  localparam logic [HITS_W-1:0] HITS_MAX = '1;
  localparam logic [MOT_W-1:0]  MOT_MAX  = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_USE_FIRST  = 2'd0,
    CFG_USE_SECOND = 2'd1,
    CFG_NEURONS    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_TRAIN = 1'b0,
    OP_LOAD  = 1'b1
  } op_e;

  typedef struct packed {
    logic                     operation;
    logic [ADDR_W-1:0]        neuron_select;
    logic signed [VAL_W-1:0]  first_value;
    logic signed [VAL_W-1:0]  second_value;
    logic [GAIN_W-1:0]        step_gain;
    logic [REACH_W-1:0]       reach;
    logic                     epoch_begin;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        winner_index;
    logic [HITS_W-1:0] winner_hits;
    logic [MOT_W-1:0]  weight_motion;
  } out_item_t;

  typedef struct packed {
    logic               use_first;
    logic               use_second;
    logic [REACH_W-1:0] neurons_in_use;
  } cfg_t;

  typedef struct packed {
    logic in_ready;
    logic latch;
    logic load_wr;
    logic scan_issue;
    logic hit_rd;
    logic hit_wr;
    logic div_start;
    logic gain_ld;
    logic slot_adv;
    logic pull_rd;
    logic pull_mag;
    logic pull_mul;
    logic pull_step;
    logic pull_wr;
    logic walk_adv;
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_is_load;
    logic scan_last;
    logic pipe_busy;
    logic walk_more;
    logic div_busy;
    logic slot_on;
    logic slot_last;
    logic out_free;
  } sts_t;
endpackage
`default_nettype wire

>>> design/rsom_if.sv
// Handshake channels of the ring map: input items, results, register writes.
// Depends on rsom_pkg.
`default_nettype none
interface rsom_in_if;
  import rsom_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic [ADDR_W-1:0]       neuron_select;
  logic signed [VAL_W-1:0] first_value;
  logic signed [VAL_W-1:0] second_value;
  logic [GAIN_W-1:0]       step_gain;
  logic [REACH_W-1:0]      reach;
  logic                    epoch_begin;
  modport source (output valid, operation, neuron_select, first_value, second_value,
                  step_gain, reach, epoch_begin, input ready);
  modport sink (input valid, operation, neuron_select, first_value, second_value,
                step_gain, reach, epoch_begin, output ready);
endinterface

interface rsom_out_if;
  import rsom_pkg::*;
  logic              valid;
  logic              ready;
  logic [7:0]        winner_index;
  logic [HITS_W-1:0] winner_hits;
  logic [MOT_W-1:0]  weight_motion;
  modport source (output valid, winner_index, winner_hits, weight_motion, input ready);
  modport sink (input valid, winner_index, winner_hits, weight_motion, output ready);
endinterface

interface rsom_cfg_if;
  import rsom_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> design/rsom_div.sv
// Restoring divider, one quotient bit per cycle, for the neighbourhood factor.
// Depends on rsom_pkg.
`default_nettype none
module rsom_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rsom_pkg::DIVD_W-1:0]  dividend_i,
  input  logic [rsom_pkg::REACH_W-1:0] divisor_i,
  output logic                         busy_o,
  output logic [rsom_pkg::F_W-1:0]     quotient_o
);
  import rsom_pkg::*;

  logic              busy_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [REACH_W-1:0] rem_q;
  logic [DIVD_W-1:0] quo_q;
  logic [REACH_W:0]  trial;
  logic              ge;

  assign trial = {rem_q, quo_q[DIVD_W-1]};
  assign ge    = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DIVD_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= ge ? REACH_W'(trial - {1'b0, divisor_i}) : trial[REACH_W-1:0];
      quo_q <= {quo_q[DIVD_W-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q[F_W-1:0];
endmodule
`default_nettype wire

>>> design/rsom_ctrl.sv
// Sequencer of the ring map: load, scan, win count, neighbourhood walk, result.
// Depends on rsom_pkg; drives the datapath through cmd_t, reads sts_t.
`default_nettype none
module rsom_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rsom_pkg::sts_t sts_i,
  output rsom_pkg::cmd_t cmd_o
);
  import rsom_pkg::*;

  typedef enum logic [14:0] {
    ST_IDLE      = 15'b000000000000001,
    ST_SCAN      = 15'b000000000000010,
    ST_SCAN_WAIT = 15'b000000000000100,
    ST_HIT_RD    = 15'b000000000001000,
    ST_HIT_WR    = 15'b000000000010000,
    ST_WALK      = 15'b000000000100000,
    ST_DIV       = 15'b000000001000000,
    ST_GAIN      = 15'b000000010000000,
    ST_SLOT      = 15'b000000100000000,
    ST_P_MAG     = 15'b000001000000000,
    ST_P_MUL     = 15'b000010000000000,
    ST_P_STEP    = 15'b000100000000000,
    ST_P_WR      = 15'b001000000000000,
    ST_ADV       = 15'b010000000000000,
    ST_DONE      = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          cmd_o.latch = 1'b1;
          if (sts_i.in_is_load) begin
            cmd_o.load_wr = 1'b1;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (sts_i.scan_last) state_d = ST_SCAN_WAIT;
      end
      ST_SCAN_WAIT: begin
        if (!sts_i.pipe_busy) state_d = ST_HIT_RD;
      end
      ST_HIT_RD: begin
        cmd_o.hit_rd = 1'b1;
        state_d      = ST_HIT_WR;
      end
      ST_HIT_WR: begin
        cmd_o.hit_wr = 1'b1;
        state_d      = ST_WALK;
      end
      ST_WALK: begin
        if (sts_i.walk_more) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DIV: begin
        if (!sts_i.div_busy) state_d = ST_GAIN;
      end
      ST_GAIN: begin
        cmd_o.gain_ld = 1'b1;
        state_d       = ST_SLOT;
      end
      ST_SLOT: begin
        if (sts_i.slot_on) begin
          cmd_o.pull_rd = 1'b1;
          state_d       = ST_P_MAG;
        end else if (sts_i.slot_last) begin
          state_d = ST_ADV;
        end else begin
          cmd_o.slot_adv = 1'b1;
        end
      end
      ST_P_MAG: begin
        cmd_o.pull_mag = 1'b1;
        state_d        = ST_P_MUL;
      end
      ST_P_MUL: begin
        cmd_o.pull_mul = 1'b1;
        state_d        = ST_P_STEP;
      end
      ST_P_STEP: begin
        cmd_o.pull_step = 1'b1;
        state_d         = ST_P_WR;
      end
      ST_P_WR: begin
        cmd_o.pull_wr = 1'b1;
        if (sts_i.slot_last) begin
          state_d = ST_ADV;
        end else begin
          cmd_o.slot_adv = 1'b1;
          state_d        = ST_SLOT;
        end
      end
      ST_ADV: begin
        cmd_o.walk_adv = 1'b1;
        state_d        = ST_WALK;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> design/rsom_dp.sv
// Datapath of the ring map: weight and win memories, scan pipeline, pull
// arithmetic, result register. Depends on rsom_pkg, rsom_div, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module rsom_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rsom_pkg::cmd_t      cmd_i,
  output rsom_pkg::sts_t      sts_o,
  input  logic                in_valid_i,
  input  rsom_pkg::in_item_t  item_i,
  input  rsom_pkg::cfg_t      cfg_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output rsom_pkg::out_item_t out_item_o
);
  import rsom_pkg::*;

  function automatic logic [VAL_W-1:0] abs_diff(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
    logic [VAL_W:0] d;
    d = {a[VAL_W-1], a} - {b[VAL_W-1], b};
    return d[VAL_W] ? VAL_W'(-d) : d[VAL_W-1:0];
  endfunction

  logic [VAL_W-1:0]   w1_mem [NEURON_COUNT];
  logic [VAL_W-1:0]   w2_mem [NEURON_COUNT];
  logic [HITS_W-1:0]  hits_mem [NEURON_COUNT];
  logic [NEURON_COUNT-1:0] hv_q;

  logic [VAL_W-1:0]   x1_q, x2_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [REACH_W-1:0] reach_q;
  logic [ADDR_W-1:0]  n_last;
  logic [REACH_W-1:0] niu_m1;

  logic [ADDR_W-1:0]  j_q, j1_q, j2_q;
  logic               v1_q, v2_q;
  logic [VAL_W-1:0]   w1rd_q, w2rd_q;
  logic [SQ_W-1:0]    sq1_q, sq2_q;
  logic [VAL_W-1:0]   m1, m2;
  logic [DIST_W-1:0]  dist_sum;
  logic [DIST_W-1:0]  best_d_q;
  logic [ADDR_W-1:0]  best_q;

  logic [HITS_W-1:0]  hrd_q, hits_q, hcur, hnxt;
  logic               hvrd_q;

  logic [REACH_W-1:0] df_q;
  logic [ADDR_W-1:0]  left_q, right_q, paddr, raddr;
  logic [1:0]         k_q;
  logic               div_busy;
  logic [F_W-1:0]     quo;
  logic [GF_W-1:0]    gf_q;

  logic [VAL_W-1:0]   xsel, wsel, wcur_q, mag_q, step_q;
  logic [VAL_W:0]     pdiff, wnew;
  logic               neg_q;
  logic [VAL_W+16-1:0] plo_q;
  logic [SQ_W-1:0]    phi_q;
  logic [VAL_W+GF_W:0] total;
  logic [SQ_W-1:0]    sq_q;
  logic               sqv_q;
  logic [MOT_W-1:0]   motion_q;
  logic [MOT_W:0]     msum;

  logic               out_valid_q;
  out_item_t          out_q;

  // Ring length, held to the supported range.
  assign niu_m1 = cfg_i.neurons_in_use - 1'b1;
  always_comb begin
    if (cfg_i.neurons_in_use < REACH_W'(2)) begin
      n_last = ADDR_W'(1);
    end else if (cfg_i.neurons_in_use > REACH_W'(NEURON_COUNT)) begin
      n_last = ADDR_W'(NEURON_COUNT - 1);
    end else begin
      n_last = niu_m1[ADDR_W-1:0];
    end
  end

  assign paddr = k_q[0] ? left_q : right_q;
  assign raddr = cmd_i.scan_issue ? j_q : paddr;

  // Weight memories: one write port, one registered read port each.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr) begin
      w1_mem[item_i.neuron_select] <= item_i.first_value;
      w2_mem[item_i.neuron_select] <= item_i.second_value;
    end else if (cmd_i.pull_wr) begin
      if (k_q[1]) begin
        w2_mem[paddr] <= wnew[VAL_W-1:0];
      end else begin
        w1_mem[paddr] <= wnew[VAL_W-1:0];
      end
    end
    if (cmd_i.scan_issue || cmd_i.pull_rd) begin
      w1rd_q <= w1_mem[raddr];
      w2rd_q <= w2_mem[raddr];
    end
  end

  // Win counter memory.
  assign hcur = hvrd_q ? hrd_q : '0;
  assign hnxt = (hcur == HITS_MAX) ? hcur : hcur + 1'b1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.hit_rd) begin
      hrd_q <= hits_mem[best_q];
    end
    if (cmd_i.hit_wr) begin
      hits_mem[best_q] <= hnxt;
      hits_q           <= hnxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q   <= '0;
      hvrd_q <= 1'b0;
    end else begin
      if (cmd_i.latch && item_i.operation == OP_TRAIN && item_i.epoch_begin) begin
        hv_q <= '0;
      end else if (cmd_i.hit_wr) begin
        hv_q[best_q] <= 1'b1;
      end
      if (cmd_i.hit_rd) hvrd_q <= hv_q[best_q];
    end
  end

  // Scan pipeline valids, motion update strobe and result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      sqv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q  <= cmd_i.scan_issue;
      v2_q  <= v1_q;
      sqv_q <= cmd_i.pull_wr;
      if (cmd_i.out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m1       = abs_diff(x1_q, w1rd_q);
  assign m2       = abs_diff(x2_q, w2rd_q);
  assign dist_sum = DIST_W'(sq1_q) + DIST_W'(sq2_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      x1_q     <= item_i.first_value;
      x2_q     <= item_i.second_value;
      gain_q   <= item_i.step_gain;
      reach_q  <= item_i.reach;
      j_q      <= '0;
    end else if (cmd_i.scan_issue) begin
      j_q <= j_q + 1'b1;
    end
    j1_q  <= j_q;
    j2_q  <= j1_q;
    sq1_q <= cfg_i.use_first ? m1 * m1 : '0;
    sq2_q <= cfg_i.use_second ? m2 * m2 : '0;
    if (v2_q && (j2_q == '0 || dist_sum < best_d_q)) begin
      best_d_q <= dist_sum;
      best_q   <= j2_q;
    end
  end

  // Neighbourhood walk.
  rsom_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({reach_q - df_q, 16'h0000}),
    .divisor_i  (reach_q),
    .busy_o     (div_busy),
    .quotient_o (quo)
  );

  assign xsel  = k_q[1] ? x2_q : x1_q;
  assign wsel  = k_q[1] ? w2rd_q : w1rd_q;
  assign pdiff = {xsel[VAL_W-1], xsel} - {wsel[VAL_W-1], wsel};
  assign total = (VAL_W+GF_W+1)'({phi_q, 16'h0000}) + (VAL_W+GF_W+1)'(plo_q)
                 + (VAL_W+GF_W+1)'(33'h0_8000_0000);
  assign wnew  = neg_q ? {wcur_q[VAL_W-1], wcur_q} - {1'b0, step_q}
                       : {wcur_q[VAL_W-1], wcur_q} + {1'b0, step_q};
  assign msum  = {1'b0, motion_q} + (MOT_W+1)'(sq_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.hit_wr) begin
      df_q    <= '0;
      left_q  <= best_q;
      right_q <= best_q;
    end else if (cmd_i.walk_adv) begin
      df_q    <= df_q + 1'b1;
      left_q  <= (left_q == '0) ? n_last : left_q - 1'b1;
      right_q <= (right_q == n_last) ? '0 : right_q + 1'b1;
    end
    if (cmd_i.gain_ld) begin
      gf_q <= GF_W'(gain_q) * GF_W'(quo);
      k_q  <= '0;
    end else if (cmd_i.slot_adv) begin
      k_q <= k_q + 1'b1;
    end
    if (cmd_i.pull_mag) begin
      wcur_q <= wsel;
      neg_q  <= pdiff[VAL_W];
      mag_q  <= abs_diff(xsel, wsel);
    end
    if (cmd_i.pull_mul) begin
      plo_q <= mag_q * gf_q[15:0];
      phi_q <= mag_q * gf_q[GF_W-1:16];
    end
    if (cmd_i.pull_step) begin
      step_q <= total[VAL_W+31:32];
    end
    if (cmd_i.pull_wr) begin
      sq_q <= step_q * step_q;
    end
    if (cmd_i.latch) begin
      motion_q <= '0;
    end else if (sqv_q) begin
      motion_q <= msum[MOT_W] ? MOT_MAX : msum[MOT_W-1:0];
    end
    if (cmd_i.out_ld) begin
      out_q.winner_index  <= 8'(best_q);
      out_q.winner_hits   <= hits_q;
      out_q.weight_motion <= motion_q;
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.in_valid   = in_valid_i;
    sts_o.in_is_load = item_i.operation == OP_LOAD;
    sts_o.scan_last  = j_q == n_last;
    sts_o.pipe_busy  = v1_q | v2_q;
    sts_o.walk_more  = df_q < reach_q;
    sts_o.div_busy   = div_busy;
    sts_o.slot_on    = k_q[1] ? cfg_i.use_second : cfg_i.use_first;
    sts_o.slot_last  = k_q == 2'd3;
    sts_o.out_free   = !out_valid_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `RSOM_ASSERT(a_out_no_overwrite, cmd_i.out_ld |-> !out_valid_q, "result overwritten")
  `RSOM_ASSERT(a_div_nonzero, cmd_i.div_start |-> reach_q != '0, "division by zero reach")
  `RSOM_ASSERT(a_step_bound, cmd_i.pull_wr |-> step_q <= mag_q, "step exceeds distance")
  `RSOM_ASSERT(a_motion_grows, sqv_q |=> motion_q >= $past(motion_q), "motion decreased")
endmodule
`default_nettype wire

>>> design/ring_som_training_step_top.sv
// Top level of the ring self-organizing map training step.
// Depends on rsom_pkg, rsom_if, rsom_ctrl, rsom_dp.
//
// Channels: in_i takes load and train transactions, out_o returns one result
// per train transaction, cfg_i writes the registers (ready always high; write
// only while the block is idle).
// A load transaction writes one neuron's weights in the accepting cycle and
// gives no result; in_i is ready again the next cycle.
// A train transaction scans the n neurons in use, counts the win, then walks
// reach neighbourhood steps. The winner scan reads one neuron per cycle from
// the weight memories; each neighbourhood step runs a bit-serial divider for
// the triangular factor, then one read-modify-write pull (read, magnitude,
// multiply, step, write) per enabled feature on each side, up to four,
// through the shared multipliers. One item is processed at a time.
// The result waits in an output register; in_i accepts the next transaction
// while it waits, and a train transaction holds before delivery until the
// register is free. A stalled receiver never loses or repeats a result.
// Reset clears all win counters, the control state and the registers to
// their defaults; weights are undefined until loaded.
`default_nettype none
module ring_som_training_step_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  rsom_in_if.sink    in_i,
  rsom_out_if.source out_o,
  rsom_cfg_if.sink   cfg_i
);
  import rsom_pkg::*;

  cmd_t      cmd;
  sts_t      sts;
  in_item_t  item;
  out_item_t res;
  cfg_t      cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_first      <= 1'b1;
      cfg_q.use_second     <= 1'b1;
      cfg_q.neurons_in_use <= REACH_W'(NEURON_COUNT);
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_USE_FIRST:  cfg_q.use_first      <= cfg_i.data[0];
        CFG_USE_SECOND: cfg_q.use_second     <= cfg_i.data[0];
        CFG_NEURONS:    cfg_q.neurons_in_use <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;

  assign item.operation     = in_i.operation;
  assign item.neuron_select = in_i.neuron_select;
  assign item.first_value   = in_i.first_value;
  assign item.second_value  = in_i.second_value;
  assign item.step_gain     = in_i.step_gain;
  assign item.reach         = in_i.reach;
  assign item.epoch_begin   = in_i.epoch_begin;
  assign in_i.ready         = cmd.in_ready;

  rsom_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  rsom_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_valid_i  (in_i.valid),
    .item_i      (item),
    .cfg_i       (cfg_q),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_item_o  (res)
  );

  assign out_o.winner_index  = res.winner_index;
  assign out_o.winner_hits   = res.winner_hits;
  assign out_o.weight_motion = res.weight_motion;
endmodule
`default_nettype wire
